// File: rtl/dfc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the delimited frame checker.
// Used by every module of the block; depends on nothing.
package dfc_pkg;

  // Result kinds.
  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Status codes carried in an end-of-frame result.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FORMAT   = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  // Reset values of the marker registers.
  localparam logic [7:0] START_MARKER_RST = 8'd2;
  localparam logic [7:0] END_MARKER_RST   = 8'd3;

  // Shortest legal frame: start, command, checksum and end plus one byte.
  localparam int unsigned MIN_FRAME = 5;

  // Result queue geometry.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } byte_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] payload_word;
    logic [7:0]  command;
    logic [5:0]  word_count;
    logic [1:0]  status;
    logic        last_of_run;
  } result_t;

  // Results produced by one accepted byte, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// File: rtl/dfc_regs.sv
`timescale 1ns / 1ps
// Configuration registers (start and end marker) behind an APB-style port.
// Depends on dfc_pkg.
module dfc_regs
  import dfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  start_marker,
  output logic [7:0]  end_marker
);

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START: start_marker <= pwdata[7:0];
        REG_END:   end_marker   <= pwdata[7:0];
        default:   start_marker <= start_marker;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START: prdata = {24'd0, start_marker};
      REG_END:   prdata = {24'd0, end_marker};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/dfc_parser.sv
`timescale 1ns / 1ps
// Frame state and per-byte result logic: delay line, checksum, word assembly.
// Depends on dfc_pkg.
module dfc_parser
  import dfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  byte_item_t item,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  output push_t      push
);

  logic [7:0]  delay0, delay0_next;
  logic [7:0]  delay1, delay1_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  command_hold, command_hold_next;
  logic [23:0] partial_word, partial_word_next;
  logic [5:0]  words_done, words_done_next;
  logic        format_bad, format_bad_next;

  logic        over_long;
  logic        word_done;
  logic [31:0] word_value;
  result_t     word_res;
  result_t     status_res;

  always_comb begin
    over_long         = byte_index >= 8'(MAX_FRAME);
    delay0_next       = delay0;
    delay1_next       = delay1;
    byte_index_next   = byte_index;
    running_sum_next  = running_sum;
    command_hold_next = command_hold;
    partial_word_next = partial_word;
    words_done_next   = words_done;
    format_bad_next   = format_bad;
    word_value        = {partial_word, delay1};
    word_done         = 1'b0;

    if (over_long) begin
      format_bad_next = 1'b1;
    end else begin
      if (byte_index == 8'd0 && item.rx_byte != start_marker) begin
        format_bad_next = 1'b1;
      end
      if (byte_index == 8'd1) begin
        command_hold_next = item.rx_byte;
        running_sum_next  = running_sum + item.rx_byte;
      end
      if (byte_index >= 8'd4) begin
        // The byte leaving the delay line is known to be payload.
        running_sum_next = running_sum + delay1;
        if (byte_index[1:0] == 2'd3) begin
          word_done         = 1'b1;
          partial_word_next = 24'd0;
          words_done_next   = words_done + 6'd1;
        end else begin
          partial_word_next = {partial_word[15:0], delay1};
        end
      end
      if (item.frame_end && ((9'(byte_index) + 9'd1) < 9'(MIN_FRAME)
                             || item.rx_byte != end_marker)) begin
        format_bad_next = 1'b1;
      end
      delay1_next     = delay0;
      delay0_next     = item.rx_byte;
      byte_index_next = byte_index + 8'd1;
    end

    word_res              = '0;
    word_res.result_kind  = KIND_WORD;
    word_res.payload_word = word_value;
    word_res.last_of_run  = ~item.frame_end;

    // After the shift the older delay slot holds the checksum byte.
    status_res             = '0;
    status_res.result_kind = KIND_STATUS;
    status_res.last_of_run = 1'b1;
    if (format_bad_next) begin
      status_res.status = ST_FORMAT;
    end else begin
      status_res.command    = command_hold_next;
      status_res.word_count = words_done_next;
      status_res.status     = (delay1_next != running_sum_next) ? ST_CHECKSUM : ST_OK;
    end

    push = '0;
    if (accept) begin
      if (word_done) begin
        push.first  = word_res;
        push.second = status_res;
        push.count  = item.frame_end ? 2'd2 : 2'd1;
      end else if (item.frame_end) begin
        push.first = status_res;
        push.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && item.frame_end)) begin
      delay0       <= '0;
      delay1       <= '0;
      byte_index   <= '0;
      running_sum  <= '0;
      command_hold <= '0;
      partial_word <= '0;
      words_done   <= '0;
      format_bad   <= 1'b0;
    end else if (accept) begin
      delay0       <= delay0_next;
      delay1       <= delay1_next;
      byte_index   <= byte_index_next;
      running_sum  <= running_sum_next;
      command_hold <= command_hold_next;
      partial_word <= partial_word_next;
      words_done   <= words_done_next;
      format_bad   <= format_bad_next;
    end
  end

  // A frame's final byte always returns the frame state to its start.
  assert property (@(posedge clk) disable iff (rst)
    accept && item.frame_end |=> byte_index == 8'd0 && !format_bad)
    else $error("frame state not cleared after final byte");

  // The byte count never runs past the frame limit.
  assert property (@(posedge clk) disable iff (rst)
    byte_index <= 8'(MAX_FRAME))
    else $error("byte index beyond frame limit");

endmodule

// File: rtl/dfc_out_queue.sv
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, delivers one per handshake.
// Depends on dfc_pkg.
module dfc_out_queue
  import dfc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_data
);

  result_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count, count_next;
  logic                pop;

  // Room for the worst case of two results from one byte.
  assign room         = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign result_valid = count != '0;
  assign result_data  = entries[rd_ptr];
  assign pop          = result_valid & ~result_stall;
  assign count_next   = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("results pushed without room");

  assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - QCNT_W'(1))
    else $error("queue count did not drop on delivery");

endmodule

// File: rtl/delimited_frame_checker_core.sv
`timescale 1ns / 1ps
// Delimited frame checker: one received byte per word on the input channel.
// The first result of an accepted byte is offered in the next cycle when the queue is
// empty; a status that follows a word from the same byte is offered once that word is taken.
// Throughput: one byte per cycle; the input stalls only while the four-entry result
// queue holds more than two results.
// Reset (synchronous, active high) clears frame state and the queue and sets the
// start and end markers to 2 and 3.
module delimited_frame_checker_core
  import dfc_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 255
) (
  input  logic        clk,
  input  logic        rst,
  // Byte channel.
  input  logic        byte_valid,
  output logic        byte_stall,
  input  byte_item_t  byte_data,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result_data,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       room;
  logic       accept;
  logic [7:0] start_marker;
  logic [7:0] end_marker;
  push_t      push;

  // The stall depends only on queue occupancy, never on the byte valid, so a
  // byte can be taken in every cycle while results drain at the other side.
  assign byte_stall = ~room;
  assign accept     = byte_valid & room;

  // Marker registers. Writes are expected only while no frame is in flight.
  dfc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_marker (start_marker),
    .end_marker   (end_marker)
  );

  // Per-byte logic: the frame state registers feed a short combinational path
  // that produces zero, one or two results for the accepted byte. A word that
  // completes on the final byte is delivered ahead of the status.
  dfc_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (byte_data),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .push         (push)
  );

  // Results are registered in a small queue that decouples the output stall
  // from byte acceptance.
  dfc_out_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
